/* src/npcq_pkg.sv */
// Shared constants and helpers for the nearest palette color quantizer.
`default_nettype none

package npcq_pkg;

  // Default number of palette slots.
  localparam int unsigned PaletteDepthDef = 256;

  // Width and reset value of the palette count register.
  localparam int unsigned CountW     = 9;
  localparam logic [CountW-1:0] CountReset = 9'd256;

  // Squared distance of one channel and of a whole color.
  localparam int unsigned SqW   = 16;
  localparam int unsigned DistW = 18;

  // Item kinds carried in tuser.
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  // Keep the top four bits of a channel.
  localparam logic [3:0] NibbleMask = 4'hF;

  function automatic logic [3:0] reduce_channel(input logic [7:0] v);
    reduce_channel = v[7:4] & NibbleMask;
  endfunction

endpackage

`default_nettype wire

/* src/nearest_palette_color_quantizer.sv */
// Top level of the nearest palette color quantizer: palette memory and search.
`default_nettype none

// Maps RGB888 pixels to the index of the nearest entry of a loadable palette.
// A beat with tuser low is a load: it writes red, green and blue into palette
// slot entry_index (slots at or above PALETTE_DEPTH are ignored) and produces
// no result. A beat with tuser high is a pixel: each channel is cut to its
// top four bits, then palette slots 0 to palette_count-1 (clamped to
// PALETTE_DEPTH) are read one per cycle from a memory with one write port and
// one registered read port and compared by squared Euclidean distance; ties
// keep the lowest index. The input stays closed until a pixel's result is
// loaded into the output register; a count of zero returns index 0. Loads may
// arrive back to back. New items are taken while an earlier result still
// waits on the output. Every slot searched must have been loaded since reset.
// The user must write palette_count through the cfg channel while the block
// is idle; the block does not enforce this. palette_count resets to 256.
module nearest_palette_color_quantizer #(
  parameter int unsigned PALETTE_DEPTH = npcq_pkg::PaletteDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel: palette_count.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: entry_index[7:0], red[15:8], green[23:16], blue[31:24].
  input  wire logic [31:0] s_axis_tdata,
  // tuser: kind (0 load, 1 pixel).
  input  wire logic        s_axis_tuser,
  // tlast: end_of_image.
  input  wire logic        s_axis_tlast,
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: color_index[7:0].
  output logic [7:0]       m_axis_tdata,
  // tlast: image_done.
  output logic             m_axis_tlast
);

  localparam int unsigned IdxW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned SqW  = npcq_pkg::SqW;
  localparam int unsigned DistW = npcq_pkg::DistW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_HOLD   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [npcq_pkg::CountW-1:0] count_q;

  // Input beat fields.
  logic [7:0] in_entry, in_red, in_green, in_blue;
  assign in_entry = s_axis_tdata[7:0];
  assign in_red   = s_axis_tdata[15:8];
  assign in_green = s_axis_tdata[23:16];
  assign in_blue  = s_axis_tdata[31:24];

  logic in_beat, in_load, in_pixel;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign in_load  = in_beat && (s_axis_tuser == npcq_pkg::KIND_LOAD);
  assign in_pixel = in_beat && (s_axis_tuser == npcq_pkg::KIND_PIXEL);

  assign cfg_ready_o = 1'b1;

  // Number of slots searched, clamped to the memory depth.
  logic [CntW-1:0] limit;
  always_comb begin
    if (count_q > npcq_pkg::CountW'(PALETTE_DEPTH)) begin
      limit = CntW'(PALETTE_DEPTH);
    end else begin
      limit = CntW'(count_q);
    end
  end

  // Palette memory: one write port for loads, one registered read port.
  logic [23:0] palette_mem_q [PALETTE_DEPTH];
  logic [23:0] rd_data_q;
  logic        mem_we, mem_re;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic [CntW-1:0] limit_q;

  assign mem_we = in_load && ({1'b0, in_entry} < 9'(PALETTE_DEPTH));
  assign mem_re = (state_q == ST_SEARCH) && (rd_cnt_q != limit_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem_q[in_entry[IdxW-1:0]] <= {in_red, in_green, in_blue};
    end
    if (mem_re) begin
      rd_data_q <= palette_mem_q[rd_cnt_q[IdxW-1:0]];
    end
  end

  // Pixel color held for the whole search.
  logic [3:0] pr_q, pg_q, pb_q;
  logic       eoi_q;

  // Stage one: read data valid. Stage two: channel squares valid.
  logic            s1_vld_q, s1_last_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s2_vld_q, s2_last_q;
  logic [IdxW-1:0] s2_idx_q;
  logic [SqW-1:0]  sq_r_q, sq_g_q, sq_b_q;

  function automatic logic [SqW-1:0] chan_sq(input logic [3:0] p, input logic [7:0] e);
    logic [7:0] a;
    logic [7:0] d;
    a = {p, 4'b0000};
    d = (a >= e) ? (a - e) : (e - a);
    chan_sq = SqW'(d) * SqW'(d);
  endfunction

  // Running best.
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [DistW-1:0] best_dist_q, best_dist_d;
  logic [DistW-1:0] cand_dist;
  logic             better;

  assign cand_dist = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);
  assign better    = (s2_idx_q == '0) || (cand_dist < best_dist_q);

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_index_q;
  logic       out_done_q;
  logic       out_load;

  assign out_load = (state_q == ST_HOLD) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    out_valid_d = out_valid_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_pixel) begin
          rd_cnt_d   = '0;
          best_idx_d = '0;
          state_d    = (limit == '0) ? ST_HOLD : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (mem_re) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (s2_vld_q) begin
          if (better) begin
            best_idx_d  = s2_idx_q;
            best_dist_d = cand_dist;
          end
          if (s2_last_q) begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= npcq_pkg::CountReset;
      rd_cnt_q    <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      s1_vld_q    <= mem_re;
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_pixel) begin
      pr_q    <= npcq_pkg::reduce_channel(in_red);
      pg_q    <= npcq_pkg::reduce_channel(in_green);
      pb_q    <= npcq_pkg::reduce_channel(in_blue);
      eoi_q   <= s_axis_tlast;
      limit_q <= limit;
    end
    s1_idx_q  <= rd_cnt_q[IdxW-1:0];
    s1_last_q <= (rd_cnt_q == limit_q - 1'b1);
    s2_idx_q  <= s1_idx_q;
    s2_last_q <= s1_last_q;
    sq_r_q    <= chan_sq(pr_q, rd_data_q[23:16]);
    sq_g_q    <= chan_sq(pg_q, rd_data_q[15:8]);
    sq_b_q    <= chan_sq(pb_q, rd_data_q[7:0]);
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    if (out_load) begin
      out_index_q <= 8'(best_idx_q);
      out_done_q  <= eoi_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_index_q;
  assign m_axis_tlast  = out_done_q;

endmodule

`default_nettype wire

/* src/npcq_checker.sv */
// Port-level checker for the nearest palette color quantizer, with its bind.
`default_nettype none

module npcq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result beat changed while stalled");

  // A pixel beat starts a search, so the input closes right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == npcq_pkg::KIND_PIXEL) |=>
      !s_axis_tready)
    else $error("input stayed open after a pixel beat");

  // A load beat leaves the input open for the next beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == npcq_pkg::KIND_LOAD) |=>
      s_axis_tready)
    else $error("input closed after a load beat");

  // A new result only appears at the end of a search, when the input was closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a search");

endmodule

bind nearest_palette_color_quantizer npcq_checker u_npcq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
